// ----- hdl/pee_pkg.sv -----
package pee_pkg;

  // Sizes of the operand stack and of the fixed-point format.
  localparam int STACK_DEPTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ACC_W       = 15;
  localparam int ACC_MAX     = 32767;
  localparam int DIV_STEPS   = 32 + FRAC_BITS;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

  // Character codes.
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_C_UP  = 8'h43;
  localparam logic [7:0] CH_C_LO  = 8'h63;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_FULL  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture an accepted request
    logic acc_digit;  // fold a digit into the accumulator
    logic push_num;   // push the pending integer, if any
    logic misc;       // handle 'E' or 'C'
    logic pop_b;
    logic pop_a;
    logic load_a;     // capture the a operand from the read port
    logic exec;       // first arithmetic step
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic push_res;
    logic end_pop;
    logic end_cap;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_number;
    logic is_digit;
    logic is_op;
    logic is_mul;
    logic is_div;
    logic b_zero;
    logic last;
    logic div_last;
    logic out_busy;
  } sts_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

// ----- hdl/pee_ctrl.sv -----
module pee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pee_pkg::sts_t sts,
  output pee_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DEC  = 15'b000000000000010,
    S_OP   = 15'b000000000000100,
    S_RDB  = 15'b000000000001000,
    S_RDA  = 15'b000000000010000,
    S_LDA  = 15'b000000000100000,
    S_EXEC = 15'b000000001000000,
    S_MUL2 = 15'b000000010000000,
    S_DIV  = 15'b000000100000000,
    S_DIVF = 15'b000001000000000,
    S_PUSH = 15'b000010000000000,
    S_FIN  = 15'b000100000000000,
    S_END2 = 15'b001000000000000,
    S_END3 = 15'b010000000000000,
    S_EMIT = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.in_number && sts.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.push_num = 1'b1;
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        if (sts.is_op) begin
          state_nxt = S_RDB;
        end else begin
          cmd.misc = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_RDB: begin
        cmd.pop_b = 1'b1;
        state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.pop_a = 1'b1;
        state_nxt = S_LDA;
      end
      S_LDA: begin
        cmd.load_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_mul) state_nxt = S_MUL2;
        else if (sts.is_div && !sts.b_zero) state_nxt = S_DIV;
        else state_nxt = S_PUSH;
      end
      S_MUL2: begin
        cmd.mul_fin = 1'b1;
        state_nxt = S_PUSH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DIVF;
      end
      S_DIVF: begin
        cmd.div_fin = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.last) begin
          cmd.push_num = 1'b1;
          state_nxt = S_END2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_END2: begin
        cmd.end_pop = 1'b1;
        state_nxt = S_END3;
      end
      S_END3: begin
        cmd.end_cap = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- hdl/pee_dp.sv -----
module pee_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char_code,
  input  logic                in_last_char,
  input  pee_pkg::cmd_t       cmd,
  output pee_pkg::sts_t       sts,
  output logic signed [31:0]  out_value,
  output logic [2:0]          out_status,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int AW = pee_pkg::ADDR_W;
  localparam int CW = pee_pkg::CNT_W;
  localparam int QW = pee_pkg::DIV_STEPS;

  logic [7:0]                  char_r;
  logic                        last_r;
  logic [pee_pkg::ACC_W-1:0]   acc_r;
  logic                        innum_r;
  logic [2:0]                  err_r;
  logic [CW-1:0]               cnt_r;
  logic signed [31:0]          mem [pee_pkg::STACK_DEPTH];
  logic signed [31:0]          rd_data_r;
  logic                        b_ok_r, a_ok_r, empty_r;
  logic signed [31:0]          a_r, b_r, res_r;
  logic signed [63:0]          prod_r;
  logic [32:0]                 rem_r;
  logic [QW-1:0]               quo_r;
  logic [31:0]                 dvs_r;
  logic                        dneg_r;
  logic [pee_pkg::DCNT_W-1:0]  dcnt_r;
  logic signed [31:0]          out_value_r;
  logic [2:0]                  out_status_r;
  logic                        out_valid_r;

  logic is_digit, is_add, is_sub, is_mul, is_div, is_e, is_c;
  logic [CW-1:0]     cnt_m1;
  logic              cnt_zero, full;
  logic [18:0]       acc_next;
  logic              acc_ovf;
  logic signed [63:0] num_wide, sum_wide, div_wide;
  logic              push_en;
  logic signed [31:0] push_val;
  logic              f_sat, f_under, f_div0, f_full;
  logic [2:0]        flag_code;
  logic [32:0]       rem_sh;
  logic              qbit;
  logic [32:0]       a_abs, b_abs;

  // Character decode.
  assign is_digit = (char_r >= pee_pkg::CH_ZERO) && (char_r <= pee_pkg::CH_NINE);
  assign is_add   = (char_r == pee_pkg::CH_ADD);
  assign is_sub   = (char_r == pee_pkg::CH_SUB);
  assign is_mul   = (char_r == pee_pkg::CH_MUL);
  assign is_div   = (char_r == pee_pkg::CH_DIV);
  assign is_e     = (char_r == pee_pkg::CH_E_UP) || (char_r == pee_pkg::CH_E_LO);
  assign is_c     = (char_r == pee_pkg::CH_C_UP) || (char_r == pee_pkg::CH_C_LO);

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_zero = (cnt_r == '0);
  assign full     = (cnt_r >= CW'(pee_pkg::STACK_DEPTH));

  // Decimal accumulator step.
  assign acc_next = 19'(acc_r) * 19'd10 + 19'(char_r - pee_pkg::CH_ZERO);
  assign acc_ovf  = (acc_next > 19'(pee_pkg::ACC_MAX));

  // Integer converted to fixed point.
  assign num_wide = 64'(acc_r) <<< pee_pkg::FRAC_BITS;

  // Add or subtract on the popped operands.
  assign sum_wide = is_sub ? (64'(a_r) - 64'(b_r)) : (64'(a_r) + 64'(b_r));

  // Signed quotient from the divider magnitude.
  assign div_wide = dneg_r ? -$signed(64'(quo_r)) : $signed(64'(quo_r));

  // Divider step: shift in one dividend bit and try a subtract.
  assign rem_sh = {rem_r[31:0], quo_r[QW-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_r});

  assign a_abs = a_r[31] ? (33'd0 - 33'(a_r)) : 33'(a_r);
  assign b_abs = b_r[31] ? (33'd0 - 33'(b_r)) : 33'(b_r);

  // Push selection.
  assign push_en  = (cmd.push_num && innum_r) || cmd.push_res;
  assign push_val = cmd.push_res ? res_r : pee_pkg::sat32(num_wide);

  // Error sources of this cycle, in the order the evaluation raises them.
  assign f_sat   = (cmd.acc_digit && acc_ovf)
                 || (cmd.push_num && innum_r && pee_pkg::ovf32(num_wide))
                 || (cmd.exec && (is_add || is_sub) && pee_pkg::ovf32(sum_wide))
                 || (cmd.mul_fin && pee_pkg::ovf32(prod_r >>> pee_pkg::FRAC_BITS))
                 || (cmd.div_fin && pee_pkg::ovf32(div_wide));
  assign f_under = (cmd.pop_a || cmd.pop_b) && cnt_zero;
  assign f_div0  = cmd.exec && is_div && (b_r == '0);
  assign f_full  = push_en && full;

  always_comb begin
    if (f_under) flag_code = pee_pkg::ST_UNDER;
    else if (f_div0) flag_code = pee_pkg::ST_DIV0;
    else if (f_sat) flag_code = pee_pkg::ST_SAT;
    else if (f_full) flag_code = pee_pkg::ST_FULL;
    else flag_code = pee_pkg::ST_OK;
  end

  // Stack memory with registered read of the top entry.
  always_ff @(posedge clk) begin
    if (push_en && !full) mem[cnt_r[AW-1:0]] <= push_val;
    rd_data_r <= mem[cnt_m1[AW-1:0]];
  end

  // Control state of the evaluation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      acc_r   <= '0;
      innum_r <= 1'b0;
      err_r   <= pee_pkg::ST_OK;
      dcnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      // Result register and end-of-expression clear.
      out_valid_r <= 1'b1;
      cnt_r   <= '0;
      acc_r   <= '0;
      innum_r <= 1'b0;
      err_r   <= pee_pkg::ST_OK;
    end else begin
      if (err_r == pee_pkg::ST_OK) err_r <= flag_code;

      if (cmd.acc_digit) begin
        acc_r <= acc_ovf ? pee_pkg::ACC_W'(pee_pkg::ACC_MAX) : acc_next[pee_pkg::ACC_W-1:0];
      end
      if (cmd.push_num && innum_r) begin
        acc_r   <= '0;
        innum_r <= 1'b0;
      end
      if (cmd.misc && is_e) begin
        acc_r   <= '0;
        innum_r <= 1'b1;
      end

      // Stack count.
      if (cmd.misc && is_c) cnt_r <= '0;
      else if ((cmd.pop_a || cmd.pop_b || cmd.end_pop) && !cnt_zero) cnt_r <= cnt_m1;
      else if (push_en && !full) cnt_r <= cnt_r + CW'(1);

      // Divider iteration count.
      if (cmd.exec && is_div && (b_r != '0)) dcnt_r <= pee_pkg::DCNT_W'(QW);
      else if (cmd.div_step && (dcnt_r != '0)) dcnt_r <= dcnt_r - pee_pkg::DCNT_W'(1);

      // The result leaves once the receiver takes it.
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // Operand and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_code;
      last_r <= in_last_char;
    end
    if (cmd.pop_b) b_ok_r <= !cnt_zero;
    if (cmd.pop_a) begin
      a_ok_r <= !cnt_zero;
      b_r <= b_ok_r ? rd_data_r : '0;
    end
    if (cmd.load_a) a_r <= a_ok_r ? rd_data_r : '0;
    if (cmd.exec) begin
      if (is_mul) prod_r <= 64'(a_r) * 64'(b_r);
      else if (is_div) begin
        if (b_r == '0) begin
          res_r <= (a_r > 0) ? 32'sh7FFFFFFF : ((a_r < 0) ? 32'sh80000000 : 32'sd0);
        end
        rem_r  <= '0;
        quo_r  <= QW'(a_abs) << pee_pkg::FRAC_BITS;
        dvs_r  <= b_abs[31:0];
        dneg_r <= a_r[31] ^ b_r[31];
      end else res_r <= pee_pkg::sat32(sum_wide);
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[QW-2:0], qbit};
    end
    if (cmd.mul_fin) res_r <= pee_pkg::sat32(prod_r >>> pee_pkg::FRAC_BITS);
    if (cmd.div_fin) res_r <= pee_pkg::sat32(div_wide);
    if (cmd.end_pop) empty_r <= cnt_zero;
    if (cmd.end_cap) res_r <= empty_r ? 32'sd0 : rd_data_r;
    if (cmd.emit) begin
      out_value_r  <= res_r;
      out_status_r <= (err_r != pee_pkg::ST_OK) ? err_r
                    : (empty_r ? pee_pkg::ST_EMPTY : pee_pkg::ST_OK);
    end
  end

  // The a operand is captured during the cycle after its read.
  assign sts.in_number = innum_r;
  assign sts.is_digit  = is_digit;
  assign sts.is_op     = is_add || is_sub || is_mul || is_div;
  assign sts.is_mul    = is_mul;
  assign sts.is_div    = is_div;
  assign sts.b_zero    = (b_r == '0);
  assign sts.last      = last_r;
  assign sts.div_last  = (dcnt_r == pee_pkg::DCNT_W'(1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_valid  = out_valid_r;

endmodule

// ----- hdl/postfix_expression_evaluator_core.sv -----
// Per request: a digit passes S_DEC and S_FIN, any other plain character S_DEC, S_OP and S_FIN;
// an add, subtract, divide by zero or multiply also S_RDB, S_RDA, S_LDA, S_EXEC and S_PUSH,
// with S_MUL2 for a multiply; a divide adds the one-bit-per-cycle restoring divider (48 steps).
// The last character passes S_END2 and S_END3; S_EMIT registers the result, waiting on out_ready.
// Throughput: one character at a time; a new request is taken once the previous one ends.
// Reset (rst_n, synchronous, active low) empties the stack and clears the error and number state.
module postfix_expression_evaluator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  pee_pkg::cmd_t cmd;
  pee_pkg::sts_t sts;

  // Sequencer.
  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stack, arithmetic and result register.
  pee_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .cmd          (cmd),
    .sts          (sts),
    .out_value    (out_value),
    .out_status   (out_status),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

// ----- tb/postfix_expression_evaluator_core_tb.sv -----
module postfix_expression_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of one expression, as popped at its last character.
  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         status;
  } rpn_result_t;

  // Tracks calculator state and holds the results still to come.
  class rpn_scoreboard;
    logic signed [31:0] stk[pee_pkg::STACK_DEPTH];
    int unsigned        depth;
    int unsigned        accum;
    bit                 in_num;
    logic [2:0]         err;
    rpn_result_t        pending[$];
    int                 errors;
    int                 checked;

    function void clear();
      depth = 0;
      accum = 0;
      in_num = 0;
      err = pee_pkg::ST_OK;
    endfunction

    function void flag(logic [2:0] code);
      if (err == pee_pkg::ST_OK) err = code;
    endfunction

    function logic signed [31:0] sat(longint v);
      if (v > 64'sd2147483647) begin
        flag(pee_pkg::ST_SAT);
        return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
        flag(pee_pkg::ST_SAT);
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function void push(logic signed [31:0] v);
      if (depth >= pee_pkg::STACK_DEPTH) begin
        flag(pee_pkg::ST_FULL);
        return;
      end
      stk[depth] = v;
      depth++;
    endfunction

    function longint pop_or_zero();
      if (depth == 0) begin
        flag(pee_pkg::ST_UNDER);
        return 0;
      end
      depth--;
      return longint'(stk[depth]);
    endfunction

    function void push_number();
      push(sat(longint'(accum) <<< pee_pkg::FRAC_BITS));
      in_num = 0;
      accum = 0;
    endfunction

    function void apply_op(logic [7:0] op);
      longint b;
      longint a;
      longint p;
      logic signed [31:0] r;
      b = pop_or_zero();
      a = pop_or_zero();
      if (op == pee_pkg::CH_ADD) r = sat(a + b);
      else if (op == pee_pkg::CH_SUB) r = sat(a - b);
      else if (op == pee_pkg::CH_MUL) begin
        p = a * b;
        // Arithmetic shift rounds toward minus infinity.
        r = sat(p >>> pee_pkg::FRAC_BITS);
      end else if (b == 0) begin
        flag(pee_pkg::ST_DIV0);
        r = (a > 0) ? 32'sh7FFFFFFF : ((a < 0) ? 32'sh80000000 : 32'sd0);
      end else r = sat((a <<< pee_pkg::FRAC_BITS) / b);
      push(r);
    endfunction

    // Note one accepted request and queue a result on the last character.
    function void note_request(logic [7:0] c, bit last);
      int unsigned n;
      rpn_result_t res;
      bit digit;
      digit = (c >= pee_pkg::CH_ZERO) && (c <= pee_pkg::CH_NINE);
      if (in_num && digit) begin
        n = accum * 10 + (c - pee_pkg::CH_ZERO);
        if (n > pee_pkg::ACC_MAX) begin
          n = pee_pkg::ACC_MAX;
          flag(pee_pkg::ST_SAT);
        end
        accum = n;
      end else begin
        if (in_num) push_number();
        if (c == pee_pkg::CH_ADD || c == pee_pkg::CH_SUB || c == pee_pkg::CH_MUL
            || c == pee_pkg::CH_DIV) apply_op(c);
        else if (c == pee_pkg::CH_E_UP || c == pee_pkg::CH_E_LO) begin
          in_num = 1;
          accum = 0;
        end else if (c == pee_pkg::CH_C_UP || c == pee_pkg::CH_C_LO) depth = 0;
      end
      if (!last) return;
      if (in_num) push_number();
      res.value = 0;
      if (depth != 0) begin
        depth--;
        res.value = stk[depth];
        res.status = (err != pee_pkg::ST_OK) ? err : pee_pkg::ST_OK;
      end else res.status = (err != pee_pkg::ST_OK) ? err : pee_pkg::ST_EMPTY;
      pending.push_back(res);
      clear();
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(logic signed [31:0] value, logic [2:0] status);
      rpn_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", value, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (value !== e.value) begin
        $error("value: expected %0d actual %0d", e.value, value);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_char_code = 0;
  logic in_last_char = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_value;
  logic [2:0] out_status;

  rpn_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int sent = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 4000000;

  postfix_expression_evaluator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  always #2 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL postfix_expression_evaluator_core");
      $finish;
    end
  end

  // Sample accepted requests and results at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_char_code, in_last_char);
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_status);
  end

  // Receiver readiness, with random stalls and a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one character at a falling edge and wait until it is accepted.
  // Valid stays high after acceptance until the next character or a drain.
  task automatic send_char(logic [7:0] c, bit last);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_char_code <= c;
    in_last_char <= last;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Random integer token, mostly small, sometimes long enough to saturate.
  function automatic string rand_number();
    string s;
    int nd;
    s = $urandom_range(1) ? "E" : "e";
    nd = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 3);
    for (int i = 0; i < nd; i++) s = {s, string'(8'(pee_pkg::CH_ZERO + $urandom_range(9)))};
    return s;
  endfunction

  function automatic byte rand_op();
    case ($urandom_range(3))
      0: return pee_pkg::CH_ADD;
      1: return pee_pkg::CH_SUB;
      2: return pee_pkg::CH_MUL;
      default: return pee_pkg::CH_DIV;
    endcase
  endfunction

  // One random expression: mostly well formed, some noisy or broken.
  task automatic send_random_expr();
    string s;
    int n;
    int kind;
    s = "";
    kind = $urandom_range(9);
    if (kind < 7) begin
      n = $urandom_range(1, 4);
      s = rand_number();
      for (int i = 1; i < n; i++) begin
        s = {s, rand_number(), " "};
        s = {s, string'(rand_op())};
      end
      if (kind == 0) s = {s, " ", rand_number()};
    end else if (kind == 7) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(255)))};
    end else if (kind == 8) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        s = {s, $urandom_range(1) ? rand_number() : string'(rand_op())};
      if ($urandom_range(3) == 0) s = {s, "c", rand_number()};
    end else begin
      // Deep stack, occasionally overflowing it.
      n = $urandom_range(28, 36);
      for (int i = 0; i < n; i++) s = {s, "e1"};
      s = {s, "+"};
    end
    if (s.len() == 0) s = "e";
    send_string(s);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int phase;
    string deep;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: operations, extremes and every correction.
    send_string("e3 e4+");
    send_string("E10 e3-");
    send_string("e2 e3*");
    send_string("e7 e2/");
    send_string("e5 e0/");
    send_string("e0 e3-e0/");
    send_string("e0 e0/");
    send_string("e99999");
    send_string("e32767 e32767*");
    send_string("e32767 e32767+");
    send_string("e0 e32767- e32767 -e1 -");
    send_string("e1 e3 - e3 *");
    send_string("+");
    send_string("e5 C");
    send_string("e5 c e2");
    send_string("xyz");
    send_char(8'hFF, 1);
    send_char(8'h00, 1);
    send_string("e1 e32768/");
    deep = "";
    for (int i = 0; i < 33; i++) deep = {deep, "e2"};
    send_string(deep);
    send_string("E");

    // Back-pressure: receiver holds off while the sender keeps going.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 10; i++) send_random_expr();
    join
    wait_drained();

    // Random phases across the idling mixes.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      while (sent < 420 * (phase + 1)) send_random_expr();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Covered %0d characters and %0d checked results over four idling mixes,",
             sent, sb.checked);
    $display("with saturation, underflow, divide by zero, full stack and clear cases.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS postfix_expression_evaluator_core");
    end else begin
      $display("FAIL postfix_expression_evaluator_core");
    end
    $finish;
  end
endmodule
